[hdl/iasmd_pkg.sv]
// Shared types for the integer add/subtract/multiply/divide unit.
// Holds the operation codes and sequencer states; no dependencies.
package iasmd_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDSUB,
    ST_MUL,
    ST_NEGA,
    ST_NEGB,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic sub;
  } alu_ctl_t;

endpackage

[hdl/iasmd_addsub.sv]
// Shared adder/subtractor of the integer arithmetic unit, with carry out.
// Depends on iasmd_pkg for the control struct.
module iasmd_addsub
  import iasmd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  alu_ctl_t         ctl,
  output logic [WIDTH-1:0] sum,
  output logic             cout
);

  logic [WIDTH:0] full;

  assign full = {1'b0, x} + {1'b0, (y ^ {WIDTH{ctl.sub}})} + {{WIDTH{1'b0}}, ctl.sub};
  assign sum  = full[WIDTH-1:0];
  assign cout = full[WIDTH];

endmodule

[hdl/integer_add_sub_mul_div_unit.sv]
// Integer add/subtract/multiply/divide unit: sequencer, registers, assertions.
// Depends on iasmd_pkg and iasmd_addsub (the single shared adder).
// An accepted start raises busy, which stays high until out_valid is raised;
// a divide error goes straight from idle to the output state.
// Multiply and divide retire one bit per cycle through the shared adder.
// Synchronous active-low reset returns to idle; the receiver cannot stall.
module integer_add_sub_mul_div_unit
  import iasmd_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_cmd,
  input  logic signed [DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [DATA_WIDTH-1:0] in_operand_b,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_result_value,
  output logic                         out_error_flag
);

  localparam int CW = $clog2(DATA_WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] opa_r, opa_nxt;
  logic [DATA_WIDTH-1:0] opb_r, opb_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  err_r, err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_result_r, out_result_nxt;
  logic                  out_error_r, out_error_nxt;

  logic [DATA_WIDTH-1:0] alu_x, alu_y, alu_sum;
  logic                  alu_cout;
  alu_ctl_t              alu_ctl;
  logic                  div_err;

  iasmd_addsub #(.WIDTH(DATA_WIDTH)) u_addsub (
    .x    (alu_x),
    .y    (alu_y),
    .ctl  (alu_ctl),
    .sum  (alu_sum),
    .cout (alu_cout)
  );

  assign div_err = (in_operand_b == '0) ||
                   ((in_operand_a == MIN_VAL) && (in_operand_b == '1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    acc_r        <= acc_nxt;
    opa_r        <= opa_nxt;
    opb_r        <= opb_nxt;
    cnt_r        <= cnt_nxt;
    neg_r        <= neg_nxt;
    err_r        <= err_nxt;
    out_result_r <= out_result_nxt;
    out_error_r  <= out_error_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    acc_nxt        = acc_r;
    opa_nxt        = opa_r;
    opb_nxt        = opb_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    err_nxt        = err_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    out_error_nxt  = out_error_r;
    alu_x          = opa_r;
    alu_y          = opb_r;
    alu_ctl.sub    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt = cmd_t'(in_cmd);
          opa_nxt = in_operand_a;
          opb_nxt = in_operand_b;
          acc_nxt = '0;
          cnt_nxt = '0;
          err_nxt = 1'b0;
          neg_nxt = in_operand_a[DATA_WIDTH-1] ^ in_operand_b[DATA_WIDTH-1];
          case (cmd_t'(in_cmd))
            CMD_ADD, CMD_SUB: state_nxt = ST_ADDSUB;
            CMD_MUL:          state_nxt = ST_MUL;
            CMD_DIV: begin
              if (div_err) begin
                err_nxt   = 1'b1;
                state_nxt = ST_OUT;
              end else begin
                state_nxt = ST_NEGA;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADDSUB: begin
        alu_ctl.sub    = (cmd_r == CMD_SUB);
        out_result_nxt = alu_sum;
        out_error_nxt  = 1'b0;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_MUL: begin
        alu_x = acc_r;
        alu_y = opa_r;
        if (opb_r[0]) begin
          acc_nxt = alu_sum;
        end
        opa_nxt = {opa_r[DATA_WIDTH-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[DATA_WIDTH-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_OUT;
        end
      end
      ST_NEGA: begin
        alu_x       = '0;
        alu_y       = opa_r;
        alu_ctl.sub = 1'b1;
        if (opa_r[DATA_WIDTH-1]) begin
          opa_nxt = alu_sum;
        end
        state_nxt = ST_NEGB;
      end
      ST_NEGB: begin
        alu_x       = '0;
        alu_y       = opb_r;
        alu_ctl.sub = 1'b1;
        if (opb_r[DATA_WIDTH-1]) begin
          opb_nxt = alu_sum;
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        alu_x       = {acc_r[DATA_WIDTH-2:0], opa_r[DATA_WIDTH-1]};
        alu_y       = opb_r;
        alu_ctl.sub = 1'b1;
        acc_nxt     = alu_cout ? alu_sum : alu_x;
        opa_nxt     = {opa_r[DATA_WIDTH-2:0], alu_cout};
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        alu_x       = '0;
        alu_y       = opa_r;
        alu_ctl.sub = 1'b1;
        acc_nxt     = neg_r ? alu_sum : opa_r;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        out_result_nxt = acc_r;
        out_error_nxt  = err_r;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_error_flag   = out_error_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while sequencer busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_result_r == '0))
    else $error("error result is not zero");

  a_err_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (cmd_r == CMD_DIV))
    else $error("error flag on a non-divide transaction");

endmodule
